@@ hw/rtl/sh_l2_rgb_accumulate_evaluate_unit_macros.svh @@
// Assertion macros shared by the spherical-harmonic lighting RTL.
`ifndef SH_L2_RGB_ACCUMULATE_EVALUATE_UNIT_MACROS_SVH
`define SH_L2_RGB_ACCUMULATE_EVALUATE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SHL2_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHL2_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/shl2_pkg.sv @@
// Types and constants for the spherical-harmonic lighting store.
`default_nettype none
package shl2_pkg;

   localparam int COEFF_WIDTH_DEF = 32;
   localparam int BASIS_W         = 19;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_AMB    = 2'd1,
      MODE_DIR    = 2'd2,
      MODE_SAMPLE = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic        [15:0] color_r;
      logic        [15:0] color_g;
      logic        [15:0] color_b;
   } req_type;

   typedef struct packed {
      logic [15:0] out_r;
      logic [15:0] out_g;
      logic [15:0] out_b;
      logic        saturated;
   } rsp_type;

   // Basis constants, Q.16
   localparam logic signed [BASIS_W-1:0] K_C0    = 19'sd18487;
   localparam logic signed [BASIS_W-1:0] K_C1    = 19'sd32021;
   localparam logic signed [BASIS_W-1:0] K_C20   = 19'sd71601;
   localparam logic signed [BASIS_W-1:0] K_C21   = 19'sd20670;
   localparam logic signed [BASIS_W-1:0] K_C22   = 19'sd35801;
   localparam logic signed [BASIS_W-1:0] ONE_Q16 = 19'sd65536;

endpackage
`default_nettype wire

@@ hw/rtl/shl2_rmul.sv @@
// Shared registered multiplier with round-to-nearest (ties away) scaling.
`default_nettype none
module shl2_rmul #(
   parameter int AW = 32,
   parameter int BW = 19
) (
   input  logic                    clock,
   input  logic signed [AW-1:0]    mul_a,
   input  logic signed [BW-1:0]    mul_b,
   input  logic                    mul_sh16,
   output logic signed [AW+BW-1:0] prod_raw,
   output logic signed [AW+BW-1:0] prod_rnd
);
   localparam int PW = AW + BW;

   logic signed [PW-1:0] prod_ff, prod_in;
   logic                 sh16_ff;
   logic        [PW-1:0] mag, half, rnd_mag;

   assign prod_in = PW'(mul_a) * PW'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sh16_ff <= mul_sh16;
   end

   always_comb begin
      mag      = prod_ff[PW-1] ? PW'(-prod_ff) : PW'(prod_ff);
      half     = sh16_ff ? (PW'(1) << 15) : (PW'(1) << 9);
      rnd_mag  = sh16_ff ? ((mag + half) >> 16) : ((mag + half) >> 10);
      prod_rnd = prod_ff[PW-1] ? -$signed(rnd_mag) : $signed(rnd_mag);
      prod_raw = prod_ff;
   end
endmodule
`default_nettype wire

@@ hw/rtl/sh_l2_rgb_accumulate_evaluate_unit.sv @@
// A zero direction skips the square root and the divides.
// One item at a time; every product goes through one shared multiplier, and square
// root and division share one 34-bit compare-subtract.
// Sample results sit in an output register; the next item is taken meanwhile.
// Synchronous reset clears the control state and all 27 coefficients.
`default_nettype none
`include "sh_l2_rgb_accumulate_evaluate_unit_macros.svh"
module sh_l2_rgb_accumulate_evaluate_unit #(
   parameter int COEFF_WIDTH = shl2_pkg::COEFF_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  shl2_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output shl2_pkg::rsp_type rsp_data
);
   import shl2_pkg::*;

   localparam int CW = COEFF_WIDTH;
   localparam int PW = CW + BASIS_W;
   localparam int SW = PW + 4;
   localparam logic signed [CW-1:0] CO_HI = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CO_LO = {1'b1, {(CW-1){1'b0}}};

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_LEN   = 9'b000000010,
      S_SQRT  = 9'b000000100,
      S_DIV   = 9'b000001000,
      S_BASIS = 9'b000010000,
      S_ACC   = 9'b000100000,
      S_SAMP  = 9'b001000000,
      S_CHAN  = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic signed [15:0]      dir_ff [3];
   logic signed [15:0]      dir_in [3];
   logic        [15:0]      col_ff [3];
   logic        [15:0]      col_in [3];
   logic        [31:0]      len_ff, len_in, lsh_ff, lsh_in, root_ff, root_in;
   logic        [33:0]      rem_ff, rem_in;
   logic        [16:0]      q_ff, q_in;
   logic        [4:0]       cnt_ff, cnt_in;
   logic        [1:0]       comp_ff, comp_in, c_ff, c_in;
   logic        [3:0]       op_ff, op_in, k_ff, k_in;
   logic                    phase_ff, phase_in, sat_ff, sat_in;
   logic signed [BASIS_W-1:0] d_ff [3];
   logic signed [BASIS_W-1:0] d_in [3];
   logic signed [BASIS_W-1:0] t_ff [6];
   logic signed [BASIS_W-1:0] t_in [6];
   logic signed [BASIS_W-1:0] b_ff [9];
   logic signed [BASIS_W-1:0] b_in [9];
   logic signed [SW-1:0]    sum_ff, sum_in;
   logic        [15:0]      out_ff [3];
   logic        [15:0]      out_in [3];
   logic signed [CW-1:0]    coef_ff [27];
   logic signed [CW-1:0]    coef_in [27];
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic signed [CW-1:0]      mul_a;
   logic signed [BASIS_W-1:0] mul_b;
   logic                      mul_sh16;
   logic signed [PW-1:0]      prod_raw, prod_rnd;

   logic [33:0] sub_a, sub_b;
   logic [34:0] diff;
   logic        ge;
   logic [4:0]  idx;
   logic [15:0] mag_cur;
   logic [16:0] qf;
   logic [31:0] len_sum;
   logic signed [PW:0]       acc_sum;
   logic signed [SW-1:0]     vr;
   logic signed [BASIS_W-1:0] zz3, xxyy;
   logic        out_free;

   shl2_rmul #(.AW(CW), .BW(BASIS_W)) u_rmul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_sh16 (mul_sh16),
      .prod_raw (prod_raw),
      .prod_rnd (prod_rnd)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign idx     = {k_ff, 1'b0} + {1'b0, k_ff} + {3'b000, c_ff};
   assign mag_cur = dir_ff[comp_ff][15] ? 16'(-dir_ff[comp_ff]) : 16'(dir_ff[comp_ff]);
   assign zz3     = (t_ff[2] <<< 1) + t_ff[2] - ONE_Q16;
   assign xxyy    = t_ff[4] - t_ff[5];

   // shared compare-subtract for square root and division
   always_comb begin
      if (state_ff == S_SQRT) begin
         sub_a = {rem_ff[31:0], lsh_ff[31:30]};
         sub_b = {root_ff, 2'b01};
      end else begin
         sub_a = {rem_ff[32:0], 1'b0};
         sub_b = {2'b00, root_ff};
      end
      diff = {1'b0, sub_a} - {1'b0, sub_b};
      ge   = !diff[34];
   end

   // multiplier operand select
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      mul_sh16 = 1'b1;
      unique case (state_ff)
         S_LEN: begin
            mul_a = CW'(dir_ff[comp_ff]);
            mul_b = BASIS_W'(dir_ff[comp_ff]);
         end
         S_BASIS: begin
            unique case (op_ff)
               4'd0:  begin mul_a = CW'(K_C1);  mul_b = d_ff[1]; end
               4'd1:  begin mul_a = CW'(K_C1);  mul_b = d_ff[2]; end
               4'd2:  begin mul_a = CW'(K_C1);  mul_b = d_ff[0]; end
               4'd3:  begin mul_a = CW'(d_ff[0]); mul_b = d_ff[1]; end
               4'd4:  begin mul_a = CW'(d_ff[1]); mul_b = d_ff[2]; end
               4'd5:  begin mul_a = CW'(d_ff[2]); mul_b = d_ff[2]; end
               4'd6:  begin mul_a = CW'(d_ff[0]); mul_b = d_ff[2]; end
               4'd7:  begin mul_a = CW'(d_ff[0]); mul_b = d_ff[0]; end
               4'd8:  begin mul_a = CW'(d_ff[1]); mul_b = d_ff[1]; end
               4'd9:  begin mul_a = CW'(K_C20); mul_b = t_ff[0]; end
               4'd10: begin mul_a = CW'(K_C20); mul_b = t_ff[1]; end
               4'd11: begin mul_a = CW'(K_C21); mul_b = zz3; end
               4'd12: begin mul_a = CW'(K_C20); mul_b = t_ff[3]; end
               4'd13: begin mul_a = CW'(K_C22); mul_b = xxyy; end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         S_ACC: begin
            mul_a    = $signed({{(CW-16){1'b0}}, col_ff[c_ff]});
            mul_b    = b_ff[k_ff];
            mul_sh16 = 1'b0;
         end
         S_SAMP: begin
            mul_a = coef_ff[idx];
            mul_b = b_ff[k_ff];
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      dir_in       = dir_ff;
      col_in       = col_ff;
      len_in       = len_ff;
      lsh_in       = lsh_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      c_in         = c_ff;
      op_in        = op_ff;
      k_in         = k_ff;
      phase_in     = phase_ff;
      sat_in       = sat_ff;
      d_in         = d_ff;
      t_in         = t_ff;
      b_in         = b_ff;
      sum_in       = sum_ff;
      out_in       = out_ff;
      coef_in      = coef_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      len_sum      = len_ff + prod_raw[31:0];
      acc_sum      = (PW+1)'(coef_ff[idx]) + (PW+1)'(prod_rnd);
      vr           = (sum_ff + SW'(32)) >>> 6;
      qf           = {q_ff[15:0], ge};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_data.mode;
               dir_in   = '{req_data.dir_x, req_data.dir_y, req_data.dir_z};
               col_in   = '{req_data.color_r, req_data.color_g, req_data.color_b};
               b_in[0]  = K_C0;
               k_in     = '0;
               c_in     = '0;
               comp_in  = '0;
               phase_in = 1'b0;
               len_in   = '0;
               unique case (req_data.mode)
                  MODE_CLEAR: begin
                     for (int i = 0; i < 27; i++) coef_in[i] = '0;
                  end
                  MODE_AMB: state_in = S_ACC;
                  MODE_DIR, MODE_SAMPLE: state_in = S_LEN;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_LEN: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               len_in = len_sum;
               if (comp_ff == 2'd2) begin
                  comp_in = '0;
                  cnt_in  = '0;
                  rem_in  = '0;
                  root_in = '0;
                  lsh_in  = len_sum;
                  if (len_sum == '0) begin
                     // zero vector: unit direction is all zero
                     d_in     = '{default: '0};
                     op_in    = '0;
                     state_in = S_BASIS;
                  end else begin
                     state_in = S_SQRT;
                  end
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end
         S_SQRT: begin
            lsh_in  = lsh_ff << 2;
            cnt_in  = cnt_ff + 5'd1;
            rem_in  = ge ? diff[33:0] : sub_a;
            root_in = {root_ff[30:0], ge};
            if (cnt_ff == 5'd31) begin
               state_in = S_DIV;
               comp_in  = '0;
               cnt_in   = '0;
               q_in     = '0;
               rem_in   = {3'b000, mag_cur, 15'b0};
            end
         end
         S_DIV: begin
            rem_in = ge ? diff[33:0] : sub_a;
            q_in   = qf;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               if (qf > 17'd65536) qf = 17'd65536;
               d_in[comp_ff] = dir_ff[comp_ff][15] ? -$signed({2'b00, qf})
                                                   : $signed({2'b00, qf});
               cnt_in = '0;
               q_in   = '0;
               if (comp_ff == 2'd2) begin
                  op_in    = '0;
                  phase_in = 1'b0;
                  state_in = S_BASIS;
               end else begin
                  comp_in = comp_ff + 2'd1;
                  rem_in  = {3'b000,
                             (dir_ff[comp_ff + 2'd1][15] ? 16'(-dir_ff[comp_ff + 2'd1])
                                                         : 16'(dir_ff[comp_ff + 2'd1])),
                             15'b0};
               end
            end
         end
         S_BASIS: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               unique case (op_ff)
                  4'd0:  b_in[1] = BASIS_W'(prod_rnd);
                  4'd1:  b_in[2] = BASIS_W'(prod_rnd);
                  4'd2:  b_in[3] = BASIS_W'(prod_rnd);
                  4'd3:  t_in[0] = BASIS_W'(prod_rnd);
                  4'd4:  t_in[1] = BASIS_W'(prod_rnd);
                  4'd5:  t_in[2] = BASIS_W'(prod_rnd);
                  4'd6:  t_in[3] = BASIS_W'(prod_rnd);
                  4'd7:  t_in[4] = BASIS_W'(prod_rnd);
                  4'd8:  t_in[5] = BASIS_W'(prod_rnd);
                  4'd9:  b_in[4] = BASIS_W'(prod_rnd);
                  4'd10: b_in[5] = BASIS_W'(prod_rnd);
                  4'd11: b_in[6] = BASIS_W'(prod_rnd);
                  4'd12: b_in[7] = BASIS_W'(prod_rnd);
                  4'd13: b_in[8] = BASIS_W'(prod_rnd);
                  default: b_in[0] = K_C0;
               endcase
               op_in = op_ff + 4'd1;
               if (op_ff == 4'd13) begin
                  k_in     = '0;
                  c_in     = '0;
                  sum_in   = '0;
                  sat_in   = 1'b0;
                  state_in = (mode_ff == MODE_SAMPLE) ? S_SAMP : S_ACC;
               end
            end
         end
         S_ACC: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               // saturate to the coefficient range
               if (acc_sum > (PW+1)'(CO_HI))      coef_in[idx] = CO_HI;
               else if (acc_sum < (PW+1)'(CO_LO)) coef_in[idx] = CO_LO;
               else                               coef_in[idx] = CW'(acc_sum);
               if (c_ff == 2'd2) begin
                  c_in = '0;
                  k_in = k_ff + 4'd1;
                  if (k_ff == 4'd8 || mode_ff == MODE_AMB) state_in = S_IDLE;
               end else begin
                  c_in = c_ff + 2'd1;
               end
            end
         end
         S_SAMP: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               sum_in = sum_ff + SW'(prod_rnd);
               if (k_ff == 4'd8) state_in = S_CHAN;
               else              k_in = k_ff + 4'd1;
            end
         end
         S_CHAN: begin
            // clamp at zero, saturate above full scale
            if (sum_ff[SW-1] || sum_ff == '0) begin
               out_in[c_ff] = '0;
            end else if (vr[SW-1:16] != '0) begin
               out_in[c_ff] = 16'hFFFF;
               sat_in       = 1'b1;
            end else begin
               out_in[c_ff] = vr[15:0];
            end
            k_in     = '0;
            sum_in   = '0;
            phase_in = 1'b0;
            if (c_ff == 2'd2) begin
               state_in = S_OUT;
            end else begin
               c_in     = c_ff + 2'd1;
               state_in = S_SAMP;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_data_in  = '{out_ff[0], out_ff[1], out_ff[2], sat_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 27; i++) coef_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         coef_ff      <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      dir_ff      <= dir_in;
      col_ff      <= col_in;
      len_ff      <= len_in;
      lsh_ff      <= lsh_in;
      root_ff     <= root_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      comp_ff     <= comp_in;
      c_ff        <= c_in;
      op_ff       <= op_in;
      k_ff        <= k_in;
      phase_ff    <= phase_in;
      sat_ff      <= sat_in;
      d_ff        <= d_in;
      t_ff        <= t_in;
      b_ff        <= b_in;
      sum_ff      <= sum_in;
      out_ff      <= out_in;
      rsp_data_ff <= rsp_data_in;
   end

   `SHL2_ASSERT_IMP(a_samp_mode, clock, reset, state_ff == S_SAMP,
      mode_ff == MODE_SAMPLE, "sample pass without sample item")
   `SHL2_ASSERT_IMP(a_acc_mode, clock, reset, state_ff == S_ACC,
      mode_ff == MODE_AMB || mode_ff == MODE_DIR, "accumulate pass with wrong mode")
   `SHL2_ASSERT_IMP(a_rsp_src, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == S_OUT), "result appeared outside output step")
   `SHL2_ASSERT_NXT(a_rsp_load, clock, reset, state_ff == S_OUT && out_free,
      rsp_valid_ff && state_ff == S_IDLE, "finished sample not loaded")

endmodule
`default_nettype wire

@@ verif/sh_l2_rgb_accumulate_evaluate_unit_chk.sv @@
// Checker for the SH lighting store: predicts sample results and compares them.
`timescale 1ns / 1ps
module sh_l2_rgb_accumulate_evaluate_unit_chk (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  shl2_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  shl2_pkg::rsp_type rsp_data,
   output int                errors,
   output int                pending
);
   import shl2_pkg::*;

   localparam longint COEF_HI = (longint'(1) <<< (COEFF_WIDTH_DEF - 1)) - 1;
   localparam longint COEF_LO = -COEF_HI - 1;

   longint  coeff_store[27];
   rsp_type irradiance_q[$];

   // Magnitude product, rounded half away from zero, shifted right by s.
   function automatic longint mul_round(longint a, longint b, int s);
      longint unsigned ma, mb, m;
      bit neg;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? longint'(-a) : a;
      mb = (b < 0) ? longint'(-b) : b;
      m = (ma * mb + (64'd1 << (s - 1))) >> s;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
         if (v >= r + bt) begin
            v = v - (r + bt);
            r = (r >> 1) + bt;
         end else begin
            r >>= 1;
         end
         bt >>= 2;
      end
      return r;
   endfunction

   function automatic longint unit_comp(longint x, longint unsigned n);
      longint unsigned m, q;
      m = (x < 0) ? longint'(-x) : x;
      q = (m << 32) / n;
      if (q > 65536) q = 65536;
      return (x < 0) ? -longint'(q) : longint'(q);
   endfunction

   task automatic sh_basis(input req_type it, output longint b[9]);
      longint x, y, z, dx, dy, dz;
      longint unsigned len2, n;
      x = it.dir_x;
      y = it.dir_y;
      z = it.dir_z;
      len2 = x * x + y * y + z * z;
      dx = 0;
      dy = 0;
      dz = 0;
      if (len2 != 0) begin
         n = int_sqrt(len2 << 32);
         dx = unit_comp(x, n);
         dy = unit_comp(y, n);
         dz = unit_comp(z, n);
      end
      b[0] = K_C0;
      b[1] = mul_round(K_C1, dy, 16);
      b[2] = mul_round(K_C1, dz, 16);
      b[3] = mul_round(K_C1, dx, 16);
      b[4] = mul_round(K_C20, mul_round(dx, dy, 16), 16);
      b[5] = mul_round(K_C20, mul_round(dy, dz, 16), 16);
      b[6] = mul_round(K_C21, 3 * mul_round(dz, dz, 16) - ONE_Q16, 16);
      b[7] = mul_round(K_C20, mul_round(dx, dz, 16), 16);
      b[8] = mul_round(K_C22, mul_round(dx, dx, 16) - mul_round(dy, dy, 16), 16);
   endtask

   task automatic add_term(input int k, input req_type it, input longint bv);
      longint col[3];
      longint v;
      col[0] = it.color_r;
      col[1] = it.color_g;
      col[2] = it.color_b;
      for (int c = 0; c < 3; c++) begin
         v = coeff_store[k * 3 + c] + mul_round(col[c], bv, 10);
         if (v > COEF_HI) v = COEF_HI;
         if (v < COEF_LO) v = COEF_LO;
         coeff_store[k * 3 + c] = v;
      end
   endtask

   task automatic apply_item(input req_type it);
      longint b[9];
      longint sum, v;
      logic [15:0] ch[3];
      rsp_type r;
      case (it.mode)
         MODE_CLEAR: begin
            foreach (coeff_store[i]) coeff_store[i] = 0;
         end
         MODE_AMB: begin
            add_term(0, it, K_C0);
         end
         MODE_DIR: begin
            sh_basis(it, b);
            for (int k = 0; k < 9; k++) add_term(k, it, b[k]);
         end
         default: begin
            sh_basis(it, b);
            r.saturated = 1'b0;
            for (int c = 0; c < 3; c++) begin
               sum = 0;
               for (int k = 0; k < 9; k++)
                  sum += mul_round(coeff_store[k * 3 + c], b[k], 16);
               v = 0;
               if (sum > 0) v = mul_round(sum, 1, 6);
               if (v > 65535) begin
                  v = 65535;
                  r.saturated = 1'b1;
               end
               ch[c] = v[15:0];
            end
            r.out_r = ch[0];
            r.out_g = ch[1];
            r.out_b = ch[2];
            irradiance_q.push_back(r);
         end
      endcase
   endtask

   assign pending = irradiance_q.size();

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         errors = 0;
         foreach (coeff_store[i]) coeff_store[i] = 0;
      end else begin
         // compare before predicting: a result leaving now belongs to an older item
         if (rsp_valid && !rsp_stall) begin
            if (irradiance_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               exp_r = irradiance_q.pop_front();
               if (rsp_data.out_r !== exp_r.out_r || rsp_data.out_g !== exp_r.out_g ||
                   rsp_data.out_b !== exp_r.out_b ||
                   rsp_data.saturated !== exp_r.saturated) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected r=%0d g=%0d b=%0d sat=%0b, %s",
                              exp_r.out_r, exp_r.out_g, exp_r.out_b, exp_r.saturated,
                              $sformatf("got r=%0d g=%0d b=%0d sat=%0b",
                                        rsp_data.out_r, rsp_data.out_g,
                                        rsp_data.out_b, rsp_data.saturated));
               end
            end
         end
         if (req_valid && !req_stall) apply_item(req_data);
      end
   end

endmodule

@@ verif/sh_l2_rgb_accumulate_evaluate_unit_tb.sv @@
// Stimulus and verdict for the SH lighting store testbench.
`timescale 1ns / 1ps
module sh_l2_rgb_accumulate_evaluate_unit_tb;
   import shl2_pkg::*;

   localparam int MAX_CYCLES = 2000000;

   logic    clock, reset;
   logic    req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;
   int      errors, pending, cycles;
   int      idle_pct, stall_pct;

   sh_l2_rgb_accumulate_evaluate_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   sh_l2_rgb_accumulate_evaluate_unit_chk u_chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .errors(errors), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= MAX_CYCLES) begin
            $display("sh_l2_rgb_accumulate_evaluate_unit verification failed");
            $finish;
         end
      end
   end

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   task automatic send_item(input req_type it);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      @(negedge clock);
   endtask

   function automatic req_type make_item(input mode_type m, input logic [15:0] x,
                                        input logic [15:0] y, input logic [15:0] z,
                                        input logic [15:0] cr, input logic [15:0] cg,
                                        input logic [15:0] cb);
      req_type it;
      it.mode = m;
      it.dir_x = x;
      it.dir_y = y;
      it.dir_z = z;
      it.color_r = cr;
      it.color_g = cg;
      it.color_b = cb;
      return it;
   endfunction

   function automatic logic [15:0] rand_dir_comp();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_color();
      case ($urandom_range(4))
         0: return 16'hffff;
         1: return 16'h0000;
         2: return 16'($urandom_range(20000));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type rand_item();
      int p;
      mode_type m;
      p = $urandom_range(99);
      if (p < 4) m = MODE_CLEAR;
      else if (p < 24) m = MODE_AMB;
      else if (p < 62) m = MODE_DIR;
      else m = MODE_SAMPLE;
      if ($urandom_range(9) == 0)
         return make_item(m, 0, 0, 0, rand_color(), rand_color(), rand_color());
      return make_item(m, rand_dir_comp(), rand_dir_comp(), rand_dir_comp(),
                       rand_color(), rand_color(), rand_color());
   endfunction

   initial begin
      int ph_idle[4] = '{0, 47, 0, 25};
      int ph_stall[4] = '{0, 0, 47, 25};
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      idle_pct  = 0;
      stall_pct = 0;
      reset     = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty store, every mode, axis and extreme directions
      send_item(make_item(MODE_SAMPLE, 16'h7fff, 0, 0, 0, 0, 0));
      send_item(make_item(MODE_AMB, 0, 0, 0, 16'hffff, 16'h0001, 16'h8000));
      send_item(make_item(MODE_SAMPLE, 0, 0, 0, 0, 0, 0));
      send_item(make_item(MODE_DIR, 16'h8000, 16'h8000, 16'h8000, 16'hffff, 16'h4000, 0));
      send_item(make_item(MODE_DIR, 16'h7fff, 0, 0, 16'h1234, 16'hffff, 16'h0001));
      send_item(make_item(MODE_DIR, 0, 0, 0, 16'h4000, 16'h4000, 16'h4000));
      send_item(make_item(MODE_DIR, 0, 16'h0001, 16'hffff, 16'h8000, 0, 16'hffff));
      send_item(make_item(MODE_SAMPLE, 16'h8000, 0, 0, 0, 0, 0));
      send_item(make_item(MODE_SAMPLE, 0, 16'h7fff, 0, 0, 0, 0));
      send_item(make_item(MODE_SAMPLE, 0, 0, 16'h8000, 0, 0, 0));
      send_item(make_item(MODE_SAMPLE, 16'h0001, 16'hffff, 16'h0001, 0, 0, 0));
      send_item(make_item(MODE_SAMPLE, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0));
      // drive the outputs past full scale
      repeat (14) send_item(make_item(MODE_AMB, 0, 0, 0, 16'hffff, 16'hffff, 16'hffff));
      send_item(make_item(MODE_SAMPLE, 0, 0, 0, 0, 0, 0));
      send_item(make_item(MODE_CLEAR, 16'h7fff, 16'h8000, 16'h1111, 16'hffff, 0, 0));
      send_item(make_item(MODE_SAMPLE, 16'h1000, 16'h2000, 16'h3000, 0, 0, 0));

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = ph_idle[ph];
         stall_pct = ph_stall[ph];
         if (ph == 1) begin
            // pump the z*z coefficient into saturation along the z axis
            send_item(make_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
            for (int i = 0; i < 840; i++) begin
               send_item(make_item(MODE_DIR, 0, 0, 16'h7fff, 16'hffff, 16'hffff, 16'hffff));
               if (i % 120 == 119)
                  send_item(make_item(MODE_SAMPLE, rand_dir_comp(), rand_dir_comp(),
                                      rand_dir_comp(), 0, 0, 0));
            end
            send_item(make_item(MODE_SAMPLE, 0, 16'h7fff, 0, 0, 0, 0));
            send_item(make_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0));
         end
         for (int i = 0; i < 140; i++) send_item(rand_item());
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (errors == 0)
         $display("sh_l2_rgb_accumulate_evaluate_unit verification clean");
      else
         $display("sh_l2_rgb_accumulate_evaluate_unit verification failed");
      $finish;
   end

endmodule
